// ===== design/dual_pwm_motor_encoder_move_assert.svh =====
// assertion macros for the checker file dpme_port_check.sv
`ifndef DUAL_PWM_MOTOR_ENCODER_MOVE_ASSERT_SVH
`define DUAL_PWM_MOTOR_ENCODER_MOVE_ASSERT_SVH

// condition implies consequence in the same cycle, outside reset
`define DPME_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the following cycle, outside reset
`define DPME_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/dpme_pkg.sv =====
`timescale 1ns / 1ps
package dpme_pkg;

    localparam int PWM_PERIOD  = 100;
    localparam int COUNT_WIDTH = 16;
    localparam int FULL_POWER  = 99;

    localparam int PH_W    = $clog2(PWM_PERIOD + 1);
    localparam int PWR_W   = 8;
    localparam int TGT_W   = 17;
    localparam int VAL_W   = 16;
    localparam int OCNT_W  = 16;
    localparam int TCMP_W  = (COUNT_WIDTH > TGT_W) ? COUNT_WIDTH : TGT_W;

    typedef enum logic [2:0] {
        CMD_TICK  = 3'd0,
        CMD_ENC   = 3'd1,
        CMD_SET   = 3'd2,
        CMD_MOVE  = 3'd3,
        CMD_CLEAR = 3'd4
    } cmd_t;

    // phase counter and pin pair of one pwm side (bit0 forward, bit1 backward)
    typedef struct packed {
        logic [PH_W-1:0] phase;
        logic [1:0]      pins;
    } pwm_side_t;

endpackage

// ===== design/dpme_pwm_chan.sv =====
`timescale 1ns / 1ps
module dpme_pwm_chan
    import dpme_pkg::*;
(
    input  pwm_side_t                cur,
    input  logic signed [PWR_W-1:0]  power,
    output pwm_side_t                nxt
);

    logic [PH_W-1:0]  ph;
    logic [PWR_W-1:0] power_mag;

    always_comb begin
        ph        = cur.phase + PH_W'(1);
        power_mag = power[PWR_W-1] ? PWR_W'(-power) : PWR_W'(power);
        nxt.pins  = cur.pins;
        nxt.phase = ph;
        // duty over: drop both pins
        if (PWR_W'(ph) >= power_mag) begin
            nxt.pins = 2'b00;
        end
        // period wrap: raise the pin of the sign
        if (ph >= PH_W'(PWM_PERIOD)) begin
            nxt.phase = '0;
            if (!power[PWR_W-1] && (power != '0)) begin
                nxt.pins[0] = 1'b1;
            end else if (power[PWR_W-1]) begin
                nxt.pins[1] = 1'b1;
            end
        end
    end

endmodule

// ===== design/dual_pwm_motor_encoder_move.sv =====
`timescale 1ns / 1ps
// Dual sign-magnitude PWM motor driver with encoder edge counting and moves.
// Slave channel s_*: one request per command; s_tuser carries the command
// code, s_tdata the signed left/right values and the sampled encoder levels.
// Master channel m_*: one result per request, the drive pins, both edge
// counts and the move flag as they stand after that request.
// A request taken into the input register moves on once the result register is
// free or being taken: then the state is updated and the result register is
// loaded together, and m_tvalid goes high with the loaded result.
// Throughput: one request per cycle while m_tready keeps up; all state updates
// are done by one pass of compare/increment logic between the input and result registers.
// Reset (aresetn low, synchronous) clears phases, powers, counts, pins,
// the move flag and both valid flags.
// When m_tready is low the result register holds; the input register still
// takes one more request, then s_tready falls until the result is taken.
module dual_pwm_motor_encoder_move
    import dpme_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [15:0] left_value, [31:16] right_value, [32] enc_left_level,
    // [33] enc_right_level, [39:34] zero
    input  logic [39:0] s_tdata,
    // [2:0] command
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] left_forward, [1] left_backward, [2] right_forward,
    // [3] right_backward, [19:4] left_count, [35:20] right_count,
    // [36] move_active, [39:37] zero
    output logic [39:0] m_tdata
);

    // input register
    logic                    in_valid_reg, in_valid_next;
    logic [2:0]              in_cmd_reg;
    logic signed [VAL_W-1:0] in_left_reg, in_right_reg;
    logic                    in_enc_l_reg, in_enc_r_reg;

    // block state
    pwm_side_t               left_side_reg, right_side_reg;
    pwm_side_t               left_side_next, right_side_next;
    pwm_side_t               left_tick, right_tick;
    logic signed [PWR_W-1:0] left_power_reg, right_power_reg;
    logic signed [PWR_W-1:0] left_power_next, right_power_next;
    logic signed [PWR_W-1:0] saved_left_reg, saved_right_reg;
    logic signed [PWR_W-1:0] saved_left_next, saved_right_next;
    logic [TGT_W-1:0]        left_target_reg, right_target_reg;
    logic [TGT_W-1:0]        left_target_next, right_target_next;
    logic [COUNT_WIDTH-1:0]  left_edges_reg, right_edges_reg;
    logic [COUNT_WIDTH-1:0]  left_edges_next, right_edges_next;
    logic [1:0]              last_enc_reg, last_enc_next;
    logic                    moving_reg, moving_next;

    // result register
    logic                    out_valid_reg, out_valid_next;
    logic [39:0]             out_data_reg;

    logic                    s_fire, advance;
    logic signed [TGT_W-1:0] left_ext, right_ext;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    dpme_pwm_chan u_left_chan (
        .cur   (left_side_reg),
        .power (left_power_reg),
        .nxt   (left_tick)
    );

    dpme_pwm_chan u_right_chan (
        .cur   (right_side_reg),
        .power (right_power_reg),
        .nxt   (right_tick)
    );

    function automatic logic signed [PWR_W-1:0] clamp_power(
        input logic signed [VAL_W-1:0] v
    );
        logic signed [PWR_W-1:0] r;
        if (v > VAL_W'(FULL_POWER)) begin
            r = PWR_W'(FULL_POWER);
        end else if (v < -VAL_W'(FULL_POWER)) begin
            r = -PWR_W'(FULL_POWER);
        end else begin
            r = v[PWR_W-1:0];
        end
        return r;
    endfunction

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_comb begin
        left_side_next    = left_side_reg;
        right_side_next   = right_side_reg;
        left_power_next   = left_power_reg;
        right_power_next  = right_power_reg;
        saved_left_next   = saved_left_reg;
        saved_right_next  = saved_right_reg;
        left_target_next  = left_target_reg;
        right_target_next = right_target_reg;
        left_edges_next   = left_edges_reg;
        right_edges_next  = right_edges_reg;
        last_enc_next     = last_enc_reg;
        moving_next       = moving_reg;
        left_ext          = TGT_W'(in_left_reg);
        right_ext         = TGT_W'(in_right_reg);

        case (in_cmd_reg)
            CMD_TICK: begin
                left_side_next  = left_tick;
                right_side_next = right_tick;
            end
            CMD_ENC: begin
                if (last_enc_reg[0] != in_enc_l_reg) begin
                    left_edges_next = left_edges_reg + COUNT_WIDTH'(1);
                end
                if (last_enc_reg[1] != in_enc_r_reg) begin
                    right_edges_next = right_edges_reg + COUNT_WIDTH'(1);
                end
                last_enc_next = {in_enc_r_reg, in_enc_l_reg};
            end
            CMD_SET: begin
                if (!moving_reg) begin
                    left_power_next  = clamp_power(in_left_reg);
                    right_power_next = clamp_power(in_right_reg);
                end
            end
            CMD_MOVE: begin
                if (!moving_reg) begin
                    left_edges_next   = '0;
                    right_edges_next  = '0;
                    saved_left_next   = left_power_reg;
                    saved_right_next  = right_power_reg;
                    left_power_next   = in_left_reg[VAL_W-1] ?
                                        -PWR_W'(FULL_POWER) : PWR_W'(FULL_POWER);
                    right_power_next  = in_right_reg[VAL_W-1] ?
                                        -PWR_W'(FULL_POWER) : PWR_W'(FULL_POWER);
                    left_target_next  = left_ext[TGT_W-1] ? TGT_W'(-left_ext)
                                                          : TGT_W'(left_ext);
                    right_target_next = right_ext[TGT_W-1] ? TGT_W'(-right_ext)
                                                           : TGT_W'(right_ext);
                    moving_next       = 1'b1;
                end
            end
            CMD_CLEAR: begin
                if (!moving_reg) begin
                    left_edges_next  = '0;
                    right_edges_next = '0;
                end
            end
            default: begin
            end
        endcase

        // completion check on the updated counts, the starting request included
        if (moving_next) begin
            if (TCMP_W'(left_edges_next) >= TCMP_W'(left_target_next)) begin
                left_power_next = '0;
            end
            if (TCMP_W'(right_edges_next) >= TCMP_W'(right_target_next)) begin
                right_power_next = '0;
            end
            if ((left_power_next == '0) && (right_power_next == '0)) begin
                left_power_next  = saved_left_next;
                right_power_next = saved_right_next;
                moving_next      = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            left_side_reg    <= '0;
            right_side_reg   <= '0;
            left_power_reg   <= '0;
            right_power_reg  <= '0;
            saved_left_reg   <= '0;
            saved_right_reg  <= '0;
            left_target_reg  <= '0;
            right_target_reg <= '0;
            left_edges_reg   <= '0;
            right_edges_reg  <= '0;
            last_enc_reg     <= '0;
            moving_reg       <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                left_side_reg    <= left_side_next;
                right_side_reg   <= right_side_next;
                left_power_reg   <= left_power_next;
                right_power_reg  <= right_power_next;
                saved_left_reg   <= saved_left_next;
                saved_right_reg  <= saved_right_next;
                left_target_reg  <= left_target_next;
                right_target_reg <= right_target_next;
                left_edges_reg   <= left_edges_next;
                right_edges_reg  <= right_edges_next;
                last_enc_reg     <= last_enc_next;
                moving_reg       <= moving_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_cmd_reg   <= s_tuser;
            in_left_reg  <= s_tdata[15:0];
            in_right_reg <= s_tdata[31:16];
            in_enc_l_reg <= s_tdata[32];
            in_enc_r_reg <= s_tdata[33];
        end
        if (advance) begin
            out_data_reg <= {3'b000, moving_next,
                             OCNT_W'(right_edges_next), OCNT_W'(left_edges_next),
                             right_side_next.pins, left_side_next.pins};
        end
    end

endmodule

// ===== design/dpme_port_check.sv =====
`timescale 1ns / 1ps
`include "dual_pwm_motor_encoder_move_assert.svh"
module dpme_port_check (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    `DPME_ASSERT_NOW(a_left_pins_exclusive, aclk, aresetn, m_tvalid, !(m_tdata[0] && m_tdata[1]), "left pins both high")
    `DPME_ASSERT_NOW(a_right_pins_exclusive, aclk, aresetn, m_tvalid, !(m_tdata[2] && m_tdata[3]), "right pins both high")
    `DPME_ASSERT_NOW(a_ready_when_drained, aclk, aresetn, (!m_tvalid || m_tready), s_tready, "input stalled with free output")
    `DPME_ASSERT_NEXT(a_result_held, aclk, aresetn, (m_tvalid && !m_tready), (m_tvalid && $stable(m_tdata)), "stalled result changed")

endmodule

bind dual_pwm_motor_encoder_move dpme_port_check u_port_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
